// ----- hw/rtl/qalu_pkg.sv -----
package qalu_pkg;

  localparam int W   = 32;          // component width
  localparam int F   = 16;          // fraction bits
  localparam int CW  = 3;           // command width
  localparam int STW = 2;           // status width

  localparam int OW  = W + 1;       // operand width, room for a negated minimum
  localparam int PW  = 2 * OW;      // product width
  localparam int VW  = PW + 2;      // sum of four products
  localparam int DW  = 2 * W + 1;   // squared norm of b
  localparam int QB  = W + 1;       // quotient and root bits
  localparam int RW  = DW + 1;      // division partial remainder
  localparam int XW  = VW + F;      // scaled dividend
  localparam int RDW = 2 * QB;      // radicand width
  localparam int SRW = QB + 3;      // root partial remainder

  localparam logic [CW-1:0] CMD_ADD   = 3'd0;
  localparam logic [CW-1:0] CMD_SUB   = 3'd1;
  localparam logic [CW-1:0] CMD_MUL   = 3'd2;
  localparam logic [CW-1:0] CMD_SCALE = 3'd3;
  localparam logic [CW-1:0] CMD_DIV   = 3'd4;
  localparam logic [CW-1:0] CMD_NORM  = 3'd5;

  localparam logic [STW-1:0] ST_OK  = 2'd0;
  localparam logic [STW-1:0] ST_DZ  = 2'd1;
  localparam logic [STW-1:0] ST_OVF = 2'd2;

  localparam logic signed [W-1:0] R_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] R_MIN = {1'b1, {(W-1){1'b0}}};

  typedef logic signed [OW-1:0] opnd_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [VW-1:0] val_t;

  typedef struct packed {
    logic                     vld;
    logic [CW-1:0]            cmd;
    logic                     dz;
    logic [3:0][VW-1:0]       val;
    logic [3:0]               neg;
    logic [3:0]               pre;
    logic [3:0][RW-1:0]       rem;
    logic [3:0][QB-1:0]       dlo;
    logic [3:0][QB-1:0]       quo;
    logic [DW-1:0]            d;
    logic [SRW-1:0]           srem;
    logic [QB-1:0]            root;
    logic [RDW-1:0]           rad;
  } iter_t;

endpackage

// ----- hw/rtl/quaternion_alu.sv -----
// Quaternion ALU, signed Q16.16: add, subtract, Hamilton product, scale, divide, norm.
// Pipeline: 39 register stages (3 product/sum stages, one set-up stage, 33 stages of the
// shared-step divider and square root, two saturation stages).
// Throughput: one request per cycle; a stalled output holds the whole pipeline.
// Reset (rst, synchronous) clears all valid bits; data registers are not cleared.
module quaternion_alu (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,  // a_re, a_i, a_j, a_k, b_re, b_i, b_j, b_k, scalar
  input  logic [2:0]   s_tuser,  // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,  // r_re, r_i, r_j, r_k
  output logic [1:0]   m_tuser   // status
);

  localparam int W  = qalu_pkg::W;
  localparam int VW = qalu_pkg::VW;
  localparam int QB = qalu_pkg::QB;

  logic en;

  // stage 1: operands
  logic                        s1_vld;
  logic [qalu_pkg::CW-1:0]     s1_cmd;
  logic signed [W-1:0]         s1_a [4];
  logic signed [W-1:0]         s1_b [4];
  qalu_pkg::opnd_t             s1_q [4];
  qalu_pkg::opnd_t             q_next [4];
  logic signed [W-1:0]         in_a [4];
  logic signed [W-1:0]         in_b [4];
  logic signed [W-1:0]         in_sc;

  // stage 2: products
  logic                        s2_vld;
  logic [qalu_pkg::CW-1:0]     s2_cmd;
  logic signed [W-1:0]         s2_a [4];
  logic signed [W-1:0]         s2_b [4];
  qalu_pkg::prod_t             s2_prod [4][4];
  qalu_pkg::prod_t             s2_bsq [4];

  // stage 3: sums
  logic                        s3_vld;
  logic [qalu_pkg::CW-1:0]     s3_cmd;
  qalu_pkg::val_t              s3_o [4];
  logic [qalu_pkg::DW-1:0]     s3_d;
  qalu_pkg::val_t              o_next [4];
  logic [qalu_pkg::DW-1:0]     d_next;

  // divider and root steps
  qalu_pkg::iter_t             it [QB+1];
  qalu_pkg::iter_t             it_next [QB+1];

  // value forming stage
  logic                        s5_vld;
  logic [qalu_pkg::CW-1:0]     s5_cmd;
  logic                        s5_dz;
  qalu_pkg::val_t              s5_v [4];
  qalu_pkg::val_t              v_next [4];

  // output register
  logic                        o_vld;
  logic [qalu_pkg::CW-1:0]     o_cmd;
  logic signed [W-1:0]         o_r [4];
  logic [qalu_pkg::STW-1:0]    o_st;
  logic signed [W-1:0]         r_next [4];
  logic [qalu_pkg::STW-1:0]    st_next;

  assign en       = !o_vld || m_tready;
  assign s_tready = en;
  assign m_tvalid = o_vld;
  assign m_tdata  = {o_r[3], o_r[2], o_r[1], o_r[0]};
  assign m_tuser  = o_st;

  // operand preparation: the second Hamilton operand depends on the command
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      in_a[c] = s_tdata[W*c +: W];
      in_b[c] = s_tdata[W*(4+c) +: W];
    end
    in_sc = s_tdata[W*8 +: W];
    for (int c = 0; c < 4; c++) begin
      q_next[c] = qalu_pkg::opnd_t'(in_b[c]);
    end
    unique case (s_tuser)
      qalu_pkg::CMD_DIV: begin
        for (int c = 1; c < 4; c++) q_next[c] = -qalu_pkg::opnd_t'(in_b[c]);
      end
      qalu_pkg::CMD_SCALE: begin
        q_next[0] = qalu_pkg::opnd_t'(in_sc);
        for (int c = 1; c < 4; c++) q_next[c] = '0;
      end
      qalu_pkg::CMD_NORM: begin
        // a times conj(a) leaves the squared norm in the real part
        q_next[0] = qalu_pkg::opnd_t'(in_a[0]);
        for (int c = 1; c < 4; c++) q_next[c] = -qalu_pkg::opnd_t'(in_a[c]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= s_tvalid;
    end
    if (en) begin
      s1_cmd <= s_tuser;
      for (int c = 0; c < 4; c++) begin
        s1_a[c] <= in_a[c];
        s1_b[c] <= in_b[c];
        s1_q[c] <= q_next[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
    if (en) begin
      s2_cmd <= s1_cmd;
      for (int i = 0; i < 4; i++) begin
        s2_a[i]   <= s1_a[i];
        s2_b[i]   <= s1_b[i];
        s2_bsq[i] <= qalu_pkg::prod_t'(s1_b[i]) * qalu_pkg::prod_t'(s1_b[i]);
        for (int j = 0; j < 4; j++) begin
          s2_prod[i][j] <= qalu_pkg::prod_t'(s1_a[i]) * qalu_pkg::prod_t'(s1_q[j]);
        end
      end
    end
  end

  always_comb begin
    case (s2_cmd)
      qalu_pkg::CMD_ADD: begin
        for (int c = 0; c < 4; c++)
          o_next[c] = qalu_pkg::val_t'(s2_a[c]) + qalu_pkg::val_t'(s2_b[c]);
      end
      qalu_pkg::CMD_SUB: begin
        for (int c = 0; c < 4; c++)
          o_next[c] = qalu_pkg::val_t'(s2_a[c]) - qalu_pkg::val_t'(s2_b[c]);
      end
      default: begin
        o_next[0] = qalu_pkg::val_t'(s2_prod[0][0]) - qalu_pkg::val_t'(s2_prod[1][1])
                  - qalu_pkg::val_t'(s2_prod[2][2]) - qalu_pkg::val_t'(s2_prod[3][3]);
        o_next[1] = qalu_pkg::val_t'(s2_prod[0][1]) + qalu_pkg::val_t'(s2_prod[1][0])
                  + qalu_pkg::val_t'(s2_prod[2][3]) - qalu_pkg::val_t'(s2_prod[3][2]);
        o_next[2] = qalu_pkg::val_t'(s2_prod[0][2]) + qalu_pkg::val_t'(s2_prod[2][0])
                  + qalu_pkg::val_t'(s2_prod[3][1]) - qalu_pkg::val_t'(s2_prod[1][3]);
        o_next[3] = qalu_pkg::val_t'(s2_prod[0][3]) + qalu_pkg::val_t'(s2_prod[3][0])
                  + qalu_pkg::val_t'(s2_prod[1][2]) - qalu_pkg::val_t'(s2_prod[2][1]);
      end
    endcase
    d_next = s2_bsq[0][qalu_pkg::DW-1:0] + s2_bsq[1][qalu_pkg::DW-1:0]
           + s2_bsq[2][qalu_pkg::DW-1:0] + s2_bsq[3][qalu_pkg::DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
    if (en) begin
      s3_cmd <= s2_cmd;
      s3_d   <= d_next;
      for (int c = 0; c < 4; c++) s3_o[c] <= o_next[c];
    end
  end

  // set-up stage and the iteration steps
  always_comb begin
    logic [VW-1:0]            mag;
    logic [qalu_pkg::XW-1:0]  x;
    qalu_pkg::val_t           rsum;
    logic [qalu_pkg::RW-1:0]  t;
    logic [qalu_pkg::SRW-1:0] st;
    logic [qalu_pkg::SRW-1:0] tr;

    it_next[0]      = '0;
    it_next[0].vld  = s3_vld;
    it_next[0].cmd  = s3_cmd;
    it_next[0].d    = s3_d;
    it_next[0].dz   = (s3_cmd == qalu_pkg::CMD_DIV) && (s3_d == '0);
    it_next[0].rad  = s3_o[0][qalu_pkg::RDW-1:0];
    for (int c = 0; c < 4; c++) begin
      mag  = s3_o[c][VW-1] ? VW'(-s3_o[c]) : VW'(s3_o[c]);
      x    = {mag, {qalu_pkg::F{1'b0}}};
      rsum = s3_o[c] + (qalu_pkg::val_t'(1) <<< (qalu_pkg::F - 1));
      it_next[0].neg[c] = s3_o[c][VW-1];
      // quotient would need more than QB bits
      it_next[0].pre[c] = qalu_pkg::XW'(mag) >= (qalu_pkg::XW'(s3_d) << (QB - qalu_pkg::F));
      it_next[0].rem[c] = qalu_pkg::RW'(x[qalu_pkg::XW-1:QB]);
      it_next[0].dlo[c] = x[QB-1:0];
      case (s3_cmd) inside
        qalu_pkg::CMD_ADD, qalu_pkg::CMD_SUB: it_next[0].val[c] = s3_o[c];
        qalu_pkg::CMD_MUL, qalu_pkg::CMD_SCALE: it_next[0].val[c] = rsum >>> qalu_pkg::F;
        default: it_next[0].val[c] = '0;
      endcase
    end

    for (int k = 1; k <= QB; k++) begin
      it_next[k] = it[k-1];
      for (int c = 0; c < 4; c++) begin
        t = {it[k-1].rem[c][qalu_pkg::RW-2:0], it[k-1].dlo[c][QB-1]};
        it_next[k].dlo[c] = it[k-1].dlo[c] << 1;
        if (t >= qalu_pkg::RW'(it[k-1].d)) begin
          it_next[k].rem[c] = t - qalu_pkg::RW'(it[k-1].d);
          it_next[k].quo[c] = {it[k-1].quo[c][QB-2:0], 1'b1};
        end else begin
          it_next[k].rem[c] = t;
          it_next[k].quo[c] = {it[k-1].quo[c][QB-2:0], 1'b0};
        end
      end
      st = {it[k-1].srem[qalu_pkg::SRW-3:0], it[k-1].rad[qalu_pkg::RDW-1 -: 2]};
      tr = qalu_pkg::SRW'({it[k-1].root, 2'b01});
      it_next[k].rad = it[k-1].rad << 2;
      if (st >= tr) begin
        it_next[k].srem = st - tr;
        it_next[k].root = {it[k-1].root[QB-2:0], 1'b1};
      end else begin
        it_next[k].srem = st;
        it_next[k].root = {it[k-1].root[QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= QB; k++) begin
      if (rst) begin
        it[k].vld <= 1'b0;
      end else if (en) begin
        it[k] <= it_next[k];
      end
    end
  end

  // form the signed value; an oversize quotient becomes a sentinel that clamps
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      case (it[QB].cmd)
        qalu_pkg::CMD_DIV: begin
          if (it[QB].pre[c]) begin
            v_next[c] = it[QB].neg[c] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
          end else if (it[QB].neg[c]) begin
            v_next[c] = -qalu_pkg::val_t'({1'b0, it[QB].quo[c]});
          end else begin
            v_next[c] = qalu_pkg::val_t'({1'b0, it[QB].quo[c]});
          end
        end
        qalu_pkg::CMD_NORM: begin
          v_next[c] = (c == 0) ? qalu_pkg::val_t'({1'b0, it[QB].root}) : '0;
        end
        default: v_next[c] = it[QB].val[c];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (en) begin
      s5_vld <= it[QB].vld;
    end
    if (en) begin
      s5_cmd <= it[QB].cmd;
      s5_dz  <= it[QB].dz;
      for (int c = 0; c < 4; c++) s5_v[c] <= v_next[c];
    end
  end

  // saturate
  always_comb begin
    logic ovf;
    ovf = 1'b0;
    for (int c = 0; c < 4; c++) begin
      if ((&s5_v[c][VW-1:W-1]) || !(|s5_v[c][VW-1:W-1])) begin
        r_next[c] = s5_v[c][W-1:0];
      end else begin
        ovf       = 1'b1;
        r_next[c] = s5_v[c][VW-1] ? qalu_pkg::R_MIN : qalu_pkg::R_MAX;
      end
    end
    if (s5_dz) begin
      for (int c = 0; c < 4; c++) r_next[c] = '0;
      st_next = qalu_pkg::ST_DZ;
    end else if (ovf) begin
      st_next = qalu_pkg::ST_OVF;
    end else begin
      st_next = qalu_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= s5_vld;
    end
    if (en) begin
      o_cmd <= s5_cmd;
      o_st  <= st_next;
      for (int c = 0; c < 4; c++) o_r[c] <= r_next[c];
    end
  end

`ifndef NO_ASSERTIONS
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == qalu_pkg::ST_DZ |-> m_tdata == '0)
    else $error("divide by zero result not zero");

  a_dz_cmd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == qalu_pkg::ST_DZ |-> o_cmd == qalu_pkg::CMD_DIV)
    else $error("divide by zero status on a non-divide request");

  a_norm_vec: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_cmd == qalu_pkg::CMD_NORM |-> m_tdata[4*W-1:W] == '0)
    else $error("norm result has a vector part");

  a_ovf_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == qalu_pkg::ST_OVF |->
      o_r[0] == qalu_pkg::R_MAX || o_r[0] == qalu_pkg::R_MIN ||
      o_r[1] == qalu_pkg::R_MAX || o_r[1] == qalu_pkg::R_MIN ||
      o_r[2] == qalu_pkg::R_MAX || o_r[2] == qalu_pkg::R_MIN ||
      o_r[3] == qalu_pkg::R_MAX || o_r[3] == qalu_pkg::R_MIN)
    else $error("overflow status without a clamped component");
`endif

endmodule

// ----- test/quaternion_alu_tb.sv -----
module quaternion_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int F   = qalu_pkg::F;
  localparam int CW  = qalu_pkg::CW;
  localparam int STW = qalu_pkg::STW;

  localparam logic [CW-1:0] CMD_ADD   = qalu_pkg::CMD_ADD;
  localparam logic [CW-1:0] CMD_SUB   = qalu_pkg::CMD_SUB;
  localparam logic [CW-1:0] CMD_MUL   = qalu_pkg::CMD_MUL;
  localparam logic [CW-1:0] CMD_SCALE = qalu_pkg::CMD_SCALE;
  localparam logic [CW-1:0] CMD_DIV   = qalu_pkg::CMD_DIV;
  localparam logic [CW-1:0] CMD_NORM  = qalu_pkg::CMD_NORM;

  localparam logic [STW-1:0] ST_OK  = qalu_pkg::ST_OK;
  localparam logic [STW-1:0] ST_DZ  = qalu_pkg::ST_DZ;
  localparam logic [STW-1:0] ST_OVF = qalu_pkg::ST_OVF;

  localparam logic signed [31:0] R_MAX = qalu_pkg::R_MAX;
  localparam logic signed [31:0] R_MIN = qalu_pkg::R_MIN;

  typedef logic signed [127:0] big_t;
  typedef logic signed [31:0]  comp_t;

  typedef struct {
    logic [127:0]   data;
    logic [STW-1:0] status;
  } quat_result_t;

  class quat_scoreboard;
    quat_result_t pending[$];
    big_t         prod[4];
    int           errors;
    int           results;
    int           per_cmd[8];

    task report(string what, logic [127:0] got, logic [127:0] want);
      errors++;
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    function void hamilton(big_t p[4], big_t q[4]);
      prod[0] = p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3];
      prod[1] = p[0]*q[1] + q[0]*p[1] + p[2]*q[3] - q[2]*p[3];
      prod[2] = p[0]*q[2] + q[0]*p[2] + p[3]*q[1] - q[3]*p[1];
      prod[3] = p[0]*q[3] + q[0]*p[3] + p[1]*q[2] - q[1]*p[2];
    endfunction

    function big_t round_q(big_t x);
      return (x + (big_t'(1) <<< (F-1))) >>> F;
    endfunction

    function big_t root_of(big_t s);
      big_t r;
      big_t cand;
      r = 0;
      for (int i = 33; i >= 0; i--) begin
        cand = r | (big_t'(1) <<< i);
        if (cand*cand <= s) r = cand;
      end
      return r;
    endfunction

    // compute the expected result of one request and queue it
    function void note(logic [CW-1:0] cmd, logic [287:0] d);
      big_t a[4], b[4], bc[4], r[4], sc, den;
      quat_result_t res;
      logic ovf;
      for (int i = 0; i < 4; i++) begin
        a[i] = big_t'($signed(d[32*i +: 32]));
        b[i] = big_t'($signed(d[32*(i+4) +: 32]));
        r[i] = 0;
      end
      sc = big_t'($signed(d[256 +: 32]));
      res.status = ST_OK;
      per_cmd[cmd]++;
      case (cmd)
        CMD_ADD: for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
        CMD_SUB: for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
        CMD_MUL: begin
          hamilton(a, b);
          for (int i = 0; i < 4; i++) r[i] = round_q(prod[i]);
        end
        CMD_SCALE: for (int i = 0; i < 4; i++) r[i] = round_q(a[i]*sc);
        CMD_DIV: begin
          den = b[0]*b[0] + b[1]*b[1] + b[2]*b[2] + b[3]*b[3];
          if (den == 0) begin
            res.status = ST_DZ;
          end else begin
            bc[0] = b[0];
            for (int i = 1; i < 4; i++) bc[i] = -b[i];
            hamilton(a, bc);
            // signed divide truncates toward zero
            for (int i = 0; i < 4; i++) r[i] = (prod[i] <<< F) / den;
          end
        end
        CMD_NORM: r[0] = root_of(a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3]);
        default: ;
      endcase
      ovf = 0;
      for (int i = 0; i < 4; i++) begin
        if (r[i] > big_t'(R_MAX)) begin
          r[i] = big_t'(R_MAX);
          ovf = 1;
        end else if (r[i] < big_t'(R_MIN)) begin
          r[i] = big_t'(R_MIN);
          ovf = 1;
        end
        res.data[32*i +: 32] = r[i][31:0];
      end
      if (res.status == ST_OK && ovf) res.status = ST_OVF;
      pending.push_back(res);
    endfunction

    task check(logic [127:0] data, logic [STW-1:0] status);
      quat_result_t want;
      results++;
      if (pending.size() == 0) begin
        report("unexpected result", data, 0);
      end else begin
        want = pending.pop_front();
        if (data[31:0] !== want.data[31:0]) report("r_re", data[31:0], want.data[31:0]);
        if (data[63:32] !== want.data[63:32]) report("r_i", data[63:32], want.data[63:32]);
        if (data[95:64] !== want.data[95:64]) report("r_j", data[95:64], want.data[95:64]);
        if (data[127:96] !== want.data[127:96])
          report("r_k", data[127:96], want.data[127:96]);
        if (status !== want.status) report("status", status, want.status);
      end
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [287:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;
  logic [1:0]   m_tuser;

  quat_scoreboard sb;
  bit  idling;
  int  stall_left;

  quaternion_alu dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata, m_tuser);
  end

  // receiver stalls in short bursts
  always @(negedge clk) begin
    if (idling && stall_left == 0 && $urandom_range(0, 3) == 0)
      stall_left = $urandom_range(1, 5);
    m_tready <= (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  function comp_t pick_comp();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      2: case ($urandom_range(0, 3))
           0: return R_MAX;
           1: return R_MIN;
           2: return 0;
           default: return -1;
         endcase
      3: return ($signed($urandom_range(0, 8)) - 4) <<< F;
      default: return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
    endcase
  endfunction

  task send(logic [CW-1:0] cmd, logic [287:0] d);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_tvalid = 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid = 1;
    s_tuser  = cmd;
    s_tdata  = d;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task send_quat(logic [CW-1:0] cmd, comp_t a0, comp_t a1, comp_t a2, comp_t a3,
                 comp_t b0, comp_t b1, comp_t b2, comp_t b3, comp_t sc);
    send(cmd, {sc, b3, b2, b1, b0, a3, a2, a1, a0});
  endtask

  task send_random();
    logic [CW-1:0] cmd;
    comp_t c[9];
    cmd = $urandom_range(0, 19) == 0 ? CW'($urandom_range(6, 7)) : CW'($urandom_range(0, 5));
    for (int i = 0; i < 9; i++) c[i] = pick_comp();
    if (cmd == CMD_DIV && $urandom_range(0, 9) == 0)
      for (int i = 4; i < 8; i++) c[i] = 0;
    send_quat(cmd, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
  endtask

  initial begin
    sb = new();
    idling = 0;
    stall_left = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    s_tuser = CMD_ADD;
    m_tready = 1;
    repeat (8) @(negedge clk);
    rst = 0;

    // directed: extremes, each command, rounding, divide by zero, unused codes
    send_quat(CMD_ADD, R_MAX, R_MIN, 1, -1, 1, -1, R_MAX, R_MIN, 0);
    send_quat(CMD_SUB, R_MIN, R_MAX, 0, 5, 1, -1, R_MIN, 5, 0);
    send_quat(CMD_ADD, 1 << F, 2 << F, -3, 4, 5, 6, 7, 8, 0);
    send_quat(CMD_MUL, 1, 1, 1, 1, 32'h8000, 32'h8000, 32'h8000, 32'h8000, 0);
    send_quat(CMD_MUL, -1, 0, 0, 0, 32'h8000, 0, 0, 0, 0);
    send_quat(CMD_MUL, 1 << F, 2 << F, 3 << F, 4 << F, 5 << F, -6 << F, 7 << F, 8, 0);
    send_quat(CMD_MUL, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN, 0);
    send_quat(CMD_MUL, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX, 0);
    send_quat(CMD_SCALE, 1 << F, -1 << F, R_MAX, R_MIN, 0, 0, 0, 0, 2 << F);
    send_quat(CMD_SCALE, R_MIN, R_MAX, 3, -3, 0, 0, 0, 0, R_MIN);
    send_quat(CMD_SCALE, 1, 3, -1, -3, 0, 0, 0, 0, 32'h8000);
    send_quat(CMD_DIV, 1 << F, 2 << F, 3 << F, 4 << F, 0, 0, 0, 0, 0);
    send_quat(CMD_DIV, 1 << F, 2 << F, 3 << F, 4 << F, 1 << F, 2 << F, 3 << F, 4 << F, 0);
    send_quat(CMD_DIV, R_MAX, R_MIN, R_MAX, R_MIN, 1, 0, 0, 0, 0);
    send_quat(CMD_DIV, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN, 0);
    send_quat(CMD_DIV, -7 << F, 1, 0, 0, 0, 0, 3 << F, 0, 0);
    send_quat(CMD_NORM, R_MIN, R_MIN, R_MIN, R_MIN, 1, 2, 3, 4, 5);
    send_quat(CMD_NORM, R_MAX, R_MAX, R_MAX, R_MAX, 0, 0, 0, 0, 0);
    send_quat(CMD_NORM, 3 << F, 4 << F, 0, 0, 0, 0, 0, 0, 0);
    send_quat(CMD_NORM, 0, 0, 0, 0, R_MAX, 0, 0, 0, 0);
    send_quat(3'd6, 1, 2, 3, 4, 5, 6, 7, 8, 9);
    send_quat(3'd7, R_MAX, R_MIN, R_MAX, R_MIN, R_MAX, R_MIN, R_MAX, R_MIN, R_MAX);

    idling = 1;
    repeat (1450) send_random();
    // last stretch at full rate on both sides
    idling = 0;
    repeat (280) send_random();
    s_tvalid = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d results: add %0d, sub %0d, mul %0d, scale %0d, div %0d, norm %0d,",
             sb.results, sb.per_cmd[0], sb.per_cmd[1], sb.per_cmd[2], sb.per_cmd[3],
             sb.per_cmd[4], sb.per_cmd[5]);
    $display("unused codes %0d, with random stalls on both stream sides",
             sb.per_cmd[6] + sb.per_cmd[7]);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ----- quaternion_alu.f -----
hw/rtl/qalu_pkg.sv
hw/rtl/quaternion_alu.sv
test/quaternion_alu_tb.sv
